FILE: rtl/pnam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pnam_pkg;

    // saturation ceiling for squared distances
    localparam logic [61:0] DIST_MAX = {62{1'b1}};

    // wrap window for fractional differences, Q.24
    localparam logic signed [33:0] HALF_Q24 = 34'sd8388608;
    localparam logic signed [33:0] ONE_Q24  = 34'sd16777216;

    // rounding offset for Q.38 to Q.16
    localparam logic signed [56:0] ROUND_Q16 = 57'sd2097152;

    // configuration register indexes
    localparam logic [1:0] REG_REF_COUNT = 2'd0;
    localparam logic [1:0] REG_ROW_A     = 2'd1;
    localparam logic [1:0] REG_ROW_B     = 2'd2;
    localparam logic [1:0] REG_ROW_C     = 2'd3;

    // word kind on the input side
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } coord_t;

    // one table entry as stored in memory
    typedef struct packed {
        logic [7:0] sp;
        coord_t     c;
    } ref_entry_t;

    typedef struct packed {
        logic [62:0] c;
        logic [62:0] b;
        logic [62:0] a;
    } lattice_t;

    // wrap a fractional difference once into the half-cell window
    function automatic logic signed [33:0] wrap_half(input logic signed [33:0] d);
        logic signed [33:0] t;
        t = d;
        if (t < -HALF_Q24)
            t = t + ONE_Q24;
        if (t > HALF_Q24)
            t = t - ONE_Q24;
        return t;
    endfunction

    // one signed Q6.14 component of a packed lattice row
    function automatic logic signed [20:0] lat_comp(input logic [62:0] row,
                                                    input int unsigned c);
        return signed'(row[21*c +: 21]);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pnam_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pnam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/pnam_dist.sv
`timescale 1ns / 1ps
`default_nettype none

module pnam_dist
    import pnam_pkg::*;
#(
    parameter int IW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_hit,
    input  wire logic [IW-1:0] in_idx,
    input  wire coord_t        query,
    input  wire coord_t        refc,
    input  wire lattice_t      lattice,
    output logic               out_valid,
    output logic               out_hit,
    output logic [IW-1:0]      out_idx,
    output coord_t             out_refc,
    output logic [61:0]        out_dist,
    output logic               busy
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] v_reg;
    logic              hit_reg  [STAGES];
    logic [IW-1:0]     idx_reg  [STAGES];
    coord_t            refc_reg [STAGES];

    logic signed [33:0] d_reg    [3];
    logic signed [54:0] prod_reg [3][3];
    logic signed [34:0] r_reg    [3];
    logic        [61:0] sq_reg   [3];
    logic        [61:0] dist_reg;

    logic signed [33:0] d_next   [3];
    logic signed [54:0] prod_next[3][3];
    logic signed [34:0] r_next   [3];
    logic        [61:0] sq_next  [3];
    logic        [61:0] dist_next;
    logic        [63:0] sum;

    // wrapped differences
    always_comb
    begin
        d_next[0] = wrap_half(34'(query.x) - 34'(refc.x));
        d_next[1] = wrap_half(34'(query.y) - 34'(refc.y));
        d_next[2] = wrap_half(34'(query.z) - 34'(refc.z));
    end

    // lattice products, one per difference and Cartesian component
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_next[c][0] = d_reg[0] * lat_comp(lattice.a, c);
            prod_next[c][1] = d_reg[1] * lat_comp(lattice.b, c);
            prod_next[c][2] = d_reg[2] * lat_comp(lattice.c, c);
        end
    end

    // component sums rounded to Q.16
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            r_next[c] = 35'((57'(prod_reg[c][0]) + 57'(prod_reg[c][1])
                           + 57'(prod_reg[c][2]) + ROUND_Q16) >>> 22);
    end

    // saturating squares
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [34:0] m;
            m = (r_reg[c] < 0) ? 35'(-r_reg[c]) : 35'(r_reg[c]);
            if (m[34:31] != 4'd0)
                sq_next[c] = DIST_MAX;
            else
                sq_next[c] = m[30:0] * m[30:0];
        end
    end

    // saturating total
    always_comb
    begin
        sum = 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
        dist_next = (sum > 64'(DIST_MAX)) ? DIST_MAX : sum[61:0];
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[STAGES-2:0], in_valid};
    end

    // datapath and tags
    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        prod_reg <= prod_next;
        r_reg    <= r_next;
        sq_reg   <= sq_next;
        dist_reg <= dist_next;
        hit_reg[0]  <= in_hit;
        idx_reg[0]  <= in_idx;
        refc_reg[0] <= refc;
        for (int s = 1; s < STAGES; s++)
        begin
            hit_reg[s]  <= hit_reg[s-1];
            idx_reg[s]  <= idx_reg[s-1];
            refc_reg[s] <= refc_reg[s-1];
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_hit   = hit_reg[STAGES-1];
    assign out_idx   = idx_reg[STAGES-1];
    assign out_refc  = refc_reg[STAGES-1];
    assign out_dist  = dist_reg;
    assign busy      = |v_reg[STAGES-2:0];

endmodule

`default_nettype wire

FILE: rtl/periodic_nearest_atom_match_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata: slot, coord_x/y/z, species; tuser: action
// m_axis    out  tvalid/tready           tdata: match and running maximum; tuser: found
// cfg       in   cfg_wr_en, no wait      cfg_addr selects register, cfg_wdata value
//
// a load goes from accept through ST_FIN into the output register; a search
// reads n = min(ref_count, MAX_ATOMS) entries, one table read per cycle from
// the entry memory, followed by the five-stage distance pipeline.
// one word is in work at a time; a finished result waits in the output
// register while the next word may be accepted.
// reset clears control state and configuration registers; the table is not cleared.
module periodic_nearest_atom_match_top
    import pnam_pkg::*;
#(
    parameter int MAX_ATOMS = 256
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [111:0] s_axis_tdata,   // slot, coord_x, coord_y, coord_z, species
    input  wire logic         s_axis_tuser,   // action
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [239:0]      m_axis_tdata,   // match_index, match_x, match_y, match_z,
                                              // distance_sq, max_distance_sq, max_index
    output logic              m_axis_tuser,   // found
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [62:0]  cfg_wdata
);

    localparam int AW = $clog2(MAX_ATOMS);
    localparam int CW = $clog2(MAX_ATOMS + 1);

    state_t state_reg, state_next;

    logic [8:0]  ref_count_reg;
    lattice_t    lattice_reg;

    logic [CW-1:0] cnt_reg, n_reg;
    coord_t        q_reg;
    logic [7:0]    qsp_reg;
    logic          rd_v_reg;
    logic [AW-1:0] rd_idx_reg;

    logic          best_found_reg;
    logic [AW-1:0] best_idx_reg;
    logic [61:0]   best_d_reg;
    coord_t        best_c_reg;
    logic [61:0]   max_d_reg;
    logic [7:0]    max_idx_reg;

    logic          out_valid_reg;
    logic          out_found_reg;
    logic [239:0]  out_data_reg;
    logic [239:0]  out_data_next;

    logic          acc, issue, scan_done, fin_load;
    logic [CW-1:0] n_eff;
    ref_entry_t    wr_entry, rd_entry;
    logic          dv, dhit, dbusy;
    logic [AW-1:0] didx;
    coord_t        drefc;
    logic [61:0]   ddist;

    // slot modulo table depth by conditional subtraction
    function automatic logic [AW-1:0] slot_mod(input logic [7:0] s);
        logic [11:0] r;
        r = 12'(s);
        for (int k = 7; k >= 0; k--)
        begin
            if (32'(r) >= (MAX_ATOMS << k))
                r = r - 12'(MAX_ATOMS << k);
        end
        return AW'(r);
    endfunction

    assign acc   = s_axis_tvalid && s_axis_tready;
    assign n_eff = (int'(ref_count_reg) > MAX_ATOMS) ? CW'(MAX_ATOMS) : CW'(ref_count_reg);

    assign wr_entry.sp  = s_axis_tdata[111:104];
    assign wr_entry.c.x = s_axis_tdata[39:8];
    assign wr_entry.c.y = s_axis_tdata[71:40];
    assign wr_entry.c.z = s_axis_tdata[103:72];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg <= 9'd1;
            lattice_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_REF_COUNT: ref_count_reg <= cfg_wdata[8:0];
                REG_ROW_A:     lattice_reg.a <= cfg_wdata;
                REG_ROW_B:     lattice_reg.b <= cfg_wdata;
                REG_ROW_C:     lattice_reg.c <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // reference table
    pnam_ram #(
        .WIDTH ($bits(ref_entry_t)),
        .DEPTH (MAX_ATOMS)
    ) u_ram (
        .clk   (clk),
        .we    (acc && (s_axis_tuser == ACT_LOAD)),
        .waddr (slot_mod(s_axis_tdata[7:0])),
        .wdata (wr_entry),
        .re    (issue),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    // distance pipeline
    pnam_dist #(
        .IW (AW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_v_reg),
        .in_hit    (rd_entry.sp == qsp_reg),
        .in_idx    (rd_idx_reg),
        .query     (q_reg),
        .refc      (rd_entry.c),
        .lattice   (lattice_reg),
        .out_valid (dv),
        .out_hit   (dhit),
        .out_idx   (didx),
        .out_refc  (drefc),
        .out_dist  (ddist),
        .busy      (dbusy)
    );

    // sequencer next state and strobes
    always_comb
    begin
        state_next = state_reg;
        issue      = 1'b0;
        scan_done  = 1'b0;
        fin_load   = 1'b0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                    state_next = (s_axis_tuser == ACT_LOAD) ? ST_FIN : ST_SCAN;
            end
            ST_SCAN:
            begin
                issue = (cnt_reg < n_reg);
                if (!issue && !rd_v_reg && !dbusy && !dv)
                begin
                    scan_done  = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                fin_load = !out_valid_reg || m_axis_tready;
                if (fin_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // scan control and best-match tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            n_reg          <= '0;
            rd_v_reg       <= 1'b0;
            best_found_reg <= 1'b0;
            max_d_reg      <= '0;
            max_idx_reg    <= '0;
        end
        else
        begin
            rd_v_reg <= issue;
            if (acc)
            begin
                best_found_reg <= 1'b0;
                cnt_reg        <= '0;
                n_reg          <= n_eff;
            end
            if (issue)
                cnt_reg <= cnt_reg + 1'b1;
            if (dv && dhit && (!best_found_reg || ddist < best_d_reg))
                best_found_reg <= 1'b1;
            if (scan_done && best_found_reg && best_d_reg > max_d_reg)
            begin
                max_d_reg   <= best_d_reg;
                max_idx_reg <= 8'(best_idx_reg);
            end
        end
    end

    // query and best-match payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg   <= wr_entry.c;
            qsp_reg <= wr_entry.sp;
        end
        rd_idx_reg <= cnt_reg[AW-1:0];
        if (dv && dhit && (!best_found_reg || ddist < best_d_reg))
        begin
            best_idx_reg <= didx;
            best_d_reg   <= ddist;
            best_c_reg   <= drefc;
        end
    end

    // result word assembly, match fields zero on a miss
    always_comb
    begin
        out_data_next = '0;
        if (best_found_reg)
        begin
            out_data_next[7:0]     = 8'(best_idx_reg);
            out_data_next[39:8]    = best_c_reg.x;
            out_data_next[71:40]   = best_c_reg.y;
            out_data_next[103:72]  = best_c_reg.z;
            out_data_next[165:104] = best_d_reg;
        end
        out_data_next[227:166] = max_d_reg;
        out_data_next[235:228] = max_idx_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            out_found_reg <= best_found_reg;
            out_data_reg  <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_found_reg;

    // running maximum never falls
    a_max_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> max_d_reg >= $past(max_d_reg))
        else $error("running maximum decreased");

    // a reported match never exceeds the reported maximum
    a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[227:166] >= m_axis_tdata[165:104])
        else $error("match distance above running maximum");

    // scan counter stays within the searched range
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> cnt_reg <= n_reg)
        else $error("scan counter past entry count");

    // a miss reports zero distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata[165:0] == '0)
        else $error("miss with nonzero match fields");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pnam_pkg::*;

    localparam int TABLE_SIZE = 256;
    localparam int STALL_LIMIT = 5000;
    localparam logic [61:0] SAT_DIST = {62{1'b1}};

    typedef struct packed {
        logic        found;
        logic [7:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [61:0] sq_dist;
        logic [61:0] max_dist;
        logic [7:0]  max_idx;
    } match_t;

    // one directed row; found and dist typed in where known up front
    typedef struct {
        logic        act;
        logic [7:0]  slot;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [7:0]  sp;
        bit          known;
        logic        k_found;
        logic [61:0] k_dist;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [239:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_wr_en;
    logic [1:0]   cfg_addr;
    logic [62:0]  cfg_wdata;

    // predictor copy of the block state
    logic [31:0] tbl_x [TABLE_SIZE];
    logic [31:0] tbl_y [TABLE_SIZE];
    logic [31:0] tbl_z [TABLE_SIZE];
    logic [7:0]  tbl_sp [TABLE_SIZE];
    bit          tbl_loaded [TABLE_SIZE];
    logic [61:0] peak_dist;
    logic [7:0]  peak_idx;
    logic [8:0]  search_len;
    logic [62:0] lat_a, lat_b, lat_c;

    match_t pending_matches[$];
    int     errors = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     quiet_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    periodic_nearest_atom_match_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // minimum-image wrap, applied once
    function automatic longint wrap_frac(longint d);
        longint t;
        t = d;
        if (t < -(64'sd1 <<< 23))
            t = t + (64'sd1 <<< 24);
        if (t > (64'sd1 <<< 23))
            t = t - (64'sd1 <<< 24);
        return t;
    endfunction

    function automatic longint row_part(logic [62:0] row, int c);
        logic signed [20:0] v;
        v = row[21*c +: 21];
        return longint'(v);
    endfunction

    function automatic logic [61:0] square_clip(longint r);
        longint unsigned m;
        m = (r < 0) ? longint'(-r) : r;
        if (m >= (64'd1 << 31))
            return SAT_DIST;
        return m * m;
    endfunction

    function automatic logic [61:0] add_clip(logic [61:0] a, logic [61:0] b);
        logic [62:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[62] ? SAT_DIST : s[61:0];
    endfunction

    function automatic logic [61:0] cart_dist_sq(logic [31:0] qx, logic [31:0] qy,
                                                 logic [31:0] qz, int i);
        longint dx, dy, dz, v, r;
        logic [61:0] acc;
        dx = wrap_frac(longint'(signed'(qx)) - longint'(signed'(tbl_x[i])));
        dy = wrap_frac(longint'(signed'(qy)) - longint'(signed'(tbl_y[i])));
        dz = wrap_frac(longint'(signed'(qz)) - longint'(signed'(tbl_z[i])));
        acc = '0;
        for (int c = 0; c < 3; c++)
        begin
            v = dx * row_part(lat_a, c) + dy * row_part(lat_b, c)
              + dz * row_part(lat_c, c);
            r = (v + (64'sd1 <<< 21)) >>> 22;
            acc = add_clip(acc, square_clip(r));
        end
        return acc;
    endfunction

    // update predictor state for an accepted word and give its result
    function automatic match_t predict_match(logic act, logic [7:0] slot, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z,
                                             logic [7:0] sp);
        match_t res;
        int n;
        logic [61:0] d;
        res = '0;
        if (act == ACT_LOAD)
        begin
            tbl_x[slot] = x;
            tbl_y[slot] = y;
            tbl_z[slot] = z;
            tbl_sp[slot] = sp;
            tbl_loaded[slot] = 1'b1;
        end
        else
        begin
            n = (search_len > TABLE_SIZE) ? TABLE_SIZE : search_len;
            for (int i = 0; i < n; i++)
            begin
                if (tbl_sp[i] == sp)
                begin
                    d = cart_dist_sq(x, y, z, i);
                    if (!res.found || d < res.sq_dist)
                    begin
                        res.found = 1'b1;
                        res.sq_dist = d;
                        res.idx = i[7:0];
                    end
                end
            end
            if (res.found)
            begin
                res.x = tbl_x[res.idx];
                res.y = tbl_y[res.idx];
                res.z = tbl_z[res.idx];
                if (res.sq_dist > peak_dist)
                begin
                    peak_dist = res.sq_dist;
                    peak_idx = res.idx;
                end
            end
        end
        res.max_dist = peak_dist;
        res.max_idx = peak_idx;
        return res;
    endfunction

    // push one word through the input handshake
    task automatic send_word(logic act, logic [7:0] slot, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [7:0] sp, bit known = 1'b0,
                             logic k_found = 1'b0, logic [61:0] k_dist = '0);
        match_t res;
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {sp, z, y, x, slot};
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = predict_match(act, slot, x, y, z, sp);
        if (known)
        begin
            res.found = k_found;
            res.sq_dist = k_dist;
        end
        pending_matches.push_back(res);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [62:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_REF_COUNT: search_len = val[8:0];
            REG_ROW_A:     lat_a = val;
            REG_ROW_B:     lat_b = val;
            default:       lat_c = val;
        endcase
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(99) < 20)
            return $urandom();
        return $urandom_range(0, 32'h00FF_FFFF) - (($urandom_range(3) == 0) ? 32'h0100_0000 : 0);
    endfunction

    function automatic logic [7:0] rand_species();
        return ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
    endfunction

    // load every entry the next searches can reach
    task automatic fill_table(int n);
        for (int i = 0; i < n && i < TABLE_SIZE; i++)
            if (!tbl_loaded[i])
                send_word(ACT_LOAD, i[7:0], rand_coord(), rand_coord(), rand_coord(),
                          rand_species());
    endtask

    function automatic logic [62:0] rand_row(int axis);
        logic [20:0] p [3];
        for (int c = 0; c < 3; c++)
            p[c] = (c == axis) ? 21'($urandom_range(16384, 196608))
                               : 21'($urandom_range(0, 16383) - 8192);
        return {p[2], p[1], p[0]};
    endfunction

    // check each result word against the oldest expectation
    always @(posedge clk)
    begin
        match_t got, want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                   m_axis_tdata[71:40], m_axis_tdata[103:72], m_axis_tdata[165:104],
                   m_axis_tdata[227:166], m_axis_tdata[235:228]};
            if (pending_matches.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (got.found !== want.found)
                    $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
                if (got.idx !== want.idx)
                    $display("%0t: match_index exp %0d got %0d", $time, want.idx, got.idx);
                if (got.x !== want.x)
                    $display("%0t: match_x exp %h got %h", $time, want.x, got.x);
                if (got.y !== want.y)
                    $display("%0t: match_y exp %h got %h", $time, want.y, got.y);
                if (got.z !== want.z)
                    $display("%0t: match_z exp %h got %h", $time, want.z, got.z);
                if (got.sq_dist !== want.sq_dist)
                    $display("%0t: distance_sq exp %h got %h", $time, want.sq_dist,
                             got.sq_dist);
                if (got.max_dist !== want.max_dist)
                    $display("%0t: max_distance_sq exp %h got %h", $time, want.max_dist,
                             got.max_dist);
                if (got.max_idx !== want.max_idx)
                    $display("%0t: max_index exp %0d got %0d", $time, want.max_idx,
                             got.max_idx);
                if (got !== want)
                    errors++;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        row_t rows [$];
        logic [62:0] ext_rows [4];
        int n_items;
        logic act;
        logic [7:0] sp;

        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= ACT_LOAD;
        m_axis_tready <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= REG_REF_COUNT;
        cfg_wdata <= '0;
        for (int i = 0; i < TABLE_SIZE; i++)
            tbl_loaded[i] = 1'b0;
        peak_dist = '0;
        peak_idx = '0;
        search_len = 9'd1;
        lat_a = '0;
        lat_b = '0;
        lat_c = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: zero lattice makes every distance zero
        rows = '{
            '{ACT_LOAD,   8'd0,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 8'd0,
              1'b1, 1'b0, 62'd0},
            '{ACT_SEARCH, 8'd0,   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'd0,
              1'b1, 1'b1, 62'd0},
            '{ACT_SEARCH, 8'd0,   32'h0, 32'h0, 32'h0, 8'd5, 1'b1, 1'b0, 62'd0},
            '{ACT_LOAD,   8'd255, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 8'd255,
              1'b1, 1'b0, 62'd0}
        };
        foreach (rows[i])
            send_word(rows[i].act, rows[i].slot, rows[i].x, rows[i].y, rows[i].z,
                      rows[i].sp, rows[i].known, rows[i].k_found, rows[i].k_dist);
        drain();

        // directed, unit cube lattice: wrap boundaries, ties, species miss
        write_reg(REG_ROW_A, {21'd0, 21'd0, 21'd16384});
        write_reg(REG_ROW_B, {21'd0, 21'd16384, 21'd0});
        write_reg(REG_ROW_C, {21'd16384, 21'd0, 21'd0});
        write_reg(REG_REF_COUNT, 63'd4);
        rows = '{
            '{ACT_LOAD,   8'd0, 32'h0, 32'h0, 32'h0, 8'd1, 1'b0, 1'b0, 62'd0},
            '{ACT_LOAD,   8'd1, 32'h0, 32'h0, 32'h0, 8'd1, 1'b0, 1'b0, 62'd0},
            '{ACT_LOAD,   8'd2, 32'h0040_0000, 32'h0, 32'h0, 8'd2, 1'b0, 1'b0, 62'd0},
            '{ACT_LOAD,   8'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 8'd255,
              1'b0, 1'b0, 62'd0},
            '{ACT_SEARCH, 8'd0, 32'h0, 32'h0, 32'h0, 8'd1, 1'b1, 1'b1, 62'd0},
            '{ACT_SEARCH, 8'd0, 32'h0080_0000, 32'h0, 32'h0, 8'd1, 1'b0, 1'b0, 62'd0},
            '{ACT_SEARCH, 8'd0, 32'hFF80_0000, 32'h0, 32'h0, 8'd1, 1'b0, 1'b0, 62'd0},
            '{ACT_SEARCH, 8'd0, 32'h0080_0001, 32'h0, 32'h0, 8'd1, 1'b0, 1'b0, 62'd0},
            '{ACT_SEARCH, 8'd0, 32'hFF7F_FFFF, 32'h0, 32'h0, 8'd1, 1'b0, 1'b0, 62'd0},
            '{ACT_SEARCH, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd2,
              1'b0, 1'b0, 62'd0},
            '{ACT_SEARCH, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 8'd255,
              1'b0, 1'b0, 62'd0},
            '{ACT_SEARCH, 8'd0, 32'h0, 32'h0, 32'h0, 8'd9, 1'b1, 1'b0, 62'd0}
        };
        foreach (rows[i])
            send_word(rows[i].act, rows[i].slot, rows[i].x, rows[i].y, rows[i].z,
                      rows[i].sp, rows[i].known, rows[i].k_found, rows[i].k_dist);
        drain();

        // random phases over count, lattice and idling settings
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 63; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            if (ph == 4)
                ext_rows = '{63'h0, {3{21'h0F_FFFF}}, {3{21'h10_0000}}, {63{1'b1}}};
            else if (ph == 7)
                ext_rows = '{63'h0, 63'({$urandom(), $urandom()}),
                             63'({$urandom(), $urandom()}),
                             63'({$urandom(), $urandom()})};
            else
                ext_rows = '{63'h0, rand_row(0), rand_row(1), rand_row(2)};
            write_reg(REG_ROW_A, ext_rows[1]);
            write_reg(REG_ROW_B, ext_rows[2]);
            write_reg(REG_ROW_C, ext_rows[3]);
            case (ph)
                3:       write_reg(REG_REF_COUNT, 63'd256);
                9:       write_reg(REG_REF_COUNT, 63'd511);
                5:       write_reg(REG_REF_COUNT, 63'd1);
                default: write_reg(REG_REF_COUNT, 63'($urandom_range(2, 24)));
            endcase
            fill_table(int'(search_len));
            n_items = (search_len > 64) ? 30 : 140;
            repeat (n_items)
            begin
                act = ($urandom_range(99) < 60) ? ACT_SEARCH : ACT_LOAD;
                sp = rand_species();
                if (act == ACT_LOAD)
                    send_word(ACT_LOAD, ($urandom_range(3) == 0) ? 8'($urandom())
                              : 8'($urandom_range(0, 31)), rand_coord(), rand_coord(),
                              rand_coord(), sp);
                else
                    send_word(ACT_SEARCH, 8'($urandom()), rand_coord(), rand_coord(),
                              rand_coord(), sp);
            end
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
rtl/pnam_pkg.sv
rtl/pnam_ram.sv
rtl/pnam_dist.sv
rtl/periodic_nearest_atom_match_top.sv
test/tb_top.sv
